[src/dcbf_pkg.sv]
// Shared types and constants of the distance-cutoff bond finder.
package dcbf_pkg;

  // Field widths
  localparam int unsigned CoordW     = 32;
  localparam int unsigned CutoffW    = 31;
  localparam int unsigned OutIdxW    = 6;
  localparam int unsigned BondW      = 11;
  localparam int unsigned SqW        = 2 * CoordW;
  localparam int unsigned SumW       = SqW + 2;
  localparam int unsigned CutoffSqW  = 2 * CutoffW;

  // Default store capacity
  localparam int unsigned MaxParticlesDef = 64;

  // Saturation value of the frame bond counter
  localparam logic [BondW-1:0] BondSat = '1;

  // Result kind codes
  localparam logic KindBond    = 1'b0;
  localparam logic KindSummary = 1'b1;

  // One stored particle position
  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } pos_t;

  // Status of the distance pipeline tail
  typedef struct packed {
    logic valid;  // a compare result leaves the pipeline
    logic hit;    // that pair lies strictly inside the cutoff
    logic busy;   // some compare is still in flight
  } res_t;

endpackage

[src/dcbf_store.sv]
// Particle position memory: one write port, one registered read port.
module dcbf_store #(
  parameter int unsigned Depth = 64,
  parameter int unsigned IdxW  = 6
) (
  input  logic                  clk_i,
  input  logic                  wr_en_i,
  input  logic [IdxW-1:0]       wr_addr_i,
  input  dcbf_pkg::pos_t        wr_data_i,
  input  logic                  rd_en_i,
  input  logic [IdxW-1:0]       rd_addr_i,
  output dcbf_pkg::pos_t        rd_data_o
);
  import dcbf_pkg::*;

  pos_t mem_q [Depth];
  pos_t rd_data_q;

  // Store a new particle
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read one entry; hold the data while no read is issued
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[src/dcbf_dist.sv]
// Pipelined squared-distance compare of a stored particle against the new one.
module dcbf_dist #(
  parameter int unsigned IdxW = 6
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              issue_i,
  input  logic [IdxW-1:0]                   issue_idx_i,
  input  dcbf_pkg::pos_t                    pos_i,
  input  dcbf_pkg::pos_t                    cand_i,
  input  logic [dcbf_pkg::CutoffW-1:0]      cutoff_i,
  output dcbf_pkg::res_t                    res_o,
  output logic [IdxW-1:0]                   res_idx_o
);
  import dcbf_pkg::*;

  localparam int unsigned NumStg = 6;

  // Token valid bits and indices per stage
  logic [NumStg-1:0]  v_q;
  logic [IdxW-1:0]    idx_q [NumStg];

  logic [CutoffSqW-1:0]      cut_sq_q;
  logic signed [CoordW:0]    diff_d [3];
  logic signed [CoordW:0]    diff_q [3];
  logic [CoordW-1:0]         mag_d [3];
  logic [CoordW-1:0]         mag_q [3];
  logic [SqW-1:0]            sq_d [3];
  logic [SqW-1:0]            sq_q [3];
  logic [SumW-1:0]           sum_d;
  logic [SumW-1:0]           sum_q;
  logic                      hit_q;

  logic signed [CoordW-1:0]  cand_c [3];
  logic signed [CoordW-1:0]  pos_c [3];

  assign cand_c[0] = cand_i.x;
  assign cand_c[1] = cand_i.y;
  assign cand_c[2] = cand_i.z;
  assign pos_c[0]  = pos_i.x;
  assign pos_c[1]  = pos_i.y;
  assign pos_c[2]  = pos_i.z;

  // Square the cutoff; the user must change it only while the block is idle, which is not enforced here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cut_sq_q <= '0;
    end else begin
      cut_sq_q <= CutoffSqW'(cutoff_i) * CutoffSqW'(cutoff_i);
    end
  end

  // Per-axis difference, magnitude and square
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      diff_d[a] = $signed({cand_c[a][CoordW-1], cand_c[a]})
                - $signed({pos_c[a][CoordW-1], pos_c[a]});
      mag_d[a]  = diff_q[a][CoordW] ? CoordW'(-diff_q[a]) : CoordW'(diff_q[a]);
      sq_d[a]   = SqW'(mag_q[a]) * SqW'(mag_q[a]);
    end
    sum_d = SumW'(sq_q[0]) + SumW'(sq_q[1]) + SumW'(sq_q[2]);
  end

  // Advance valid bits with the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NumStg-2:0], issue_i};
    end
  end

  // Advance the datapath with the pipeline
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      idx_q[0] <= issue_idx_i;
      for (int s = 1; s < NumStg; s++) begin
        idx_q[s] <= idx_q[s-1];
      end
      for (int a = 0; a < 3; a++) begin
        diff_q[a] <= diff_d[a];
        mag_q[a]  <= mag_d[a];
        sq_q[a]   <= sq_d[a];
      end
      sum_q <= sum_d;
      hit_q <= sum_q < SumW'(cut_sq_q);
    end
  end

  assign res_o.valid = v_q[NumStg-1];
  assign res_o.hit   = v_q[NumStg-1] & hit_q;
  assign res_o.busy  = |v_q;
  assign res_idx_o   = idx_q[NumStg-1];

endmodule

[src/distance_cutoff_bond_finder.sv]
// Distance-cutoff bond finder: frame control, position store and result output.
//
// Input channel: one particle per transaction (pos_x/y/z signed Q16.16 and
// frame_end), accepted when in_valid_i is high and in_stall_o is low. The
// block stalls input while it works on a particle. Particle n is compared
// against the n particles already stored in the frame, one memory read per
// cycle while the output is not stalled; the block then drains the compare
// pipeline and flushes the last pending pair (and sends the summary on
// frame_end) before the next particle is taken. Output stalls lengthen the
// scan. Particles past capacity are dropped and flagged.
// Output channel: bond pairs in increasing earlier index, then on frame_end
// a summary with the bond count and the overflow flag; last_o marks the
// final result of each particle. A result is taken when out_valid_o is high
// and out_stall_i is low; a stall holds the output register and freezes the
// compare pipeline. Each pair is held back until the next pair or the end of
// the scan. Configuration: cutoff_distance is written through cfg_valid_i /
// cfg_ready_o; the user must write it only while the block is idle, which the
// block itself does not enforce; the port is always ready. Reset clears the
// frame counters, the cutoff and all control state; the store is not cleared.
module distance_cutoff_bond_finder #(
  parameter int unsigned MAX_PARTICLES = dcbf_pkg::MaxParticlesDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [dcbf_pkg::CutoffW-1:0]      cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [dcbf_pkg::CoordW-1:0] pos_x_i,
  input  logic signed [dcbf_pkg::CoordW-1:0] pos_y_i,
  input  logic signed [dcbf_pkg::CoordW-1:0] pos_z_i,
  input  logic                              frame_end_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              result_kind_o,
  output logic [dcbf_pkg::OutIdxW-1:0]      first_index_o,
  output logic [dcbf_pkg::OutIdxW-1:0]      second_index_o,
  output logic [dcbf_pkg::BondW-1:0]        frame_bond_count_o,
  output logic                              frame_overflow_o,
  output logic                              last_o
);
  import dcbf_pkg::*;

  localparam int unsigned IdxW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int unsigned CntW = $clog2(MAX_PARTICLES + 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_FLUSH = 5'b01000,
    ST_SUMM  = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [IdxW-1:0]   j_q, j_d;
  logic [BondW-1:0]  bonds_q, bonds_d;
  logic              ovf_q, ovf_d;
  logic              pend_valid_q, pend_valid_d;
  logic [IdxW-1:0]   pend_idx_q, pend_idx_d;
  logic [CutoffW-1:0] cutoff_q;
  pos_t              pos_q;
  logic              end_q;

  // Output register
  logic              out_valid_q, out_valid_d;
  logic              kind_q, kind_d;
  logic [OutIdxW-1:0] fidx_q, fidx_d;
  logic [OutIdxW-1:0] sidx_q, sidx_d;
  logic [BondW-1:0]  ocnt_q, ocnt_d;
  logic              oovf_q, oovf_d;
  logic              last_q, last_d;

  logic              out_free;
  logic              in_acc;
  logic              has_room;
  logic              issue;
  pos_t              in_pos;
  pos_t              cand;
  res_t              res;
  logic [IdxW-1:0]   res_idx;

  assign out_free = !out_valid_q || !out_stall_i;
  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign has_room = count_q < CntW'(MAX_PARTICLES);
  assign issue    = (state_q == ST_SCAN) && out_free;

  assign in_pos.x = pos_x_i;
  assign in_pos.y = pos_y_i;
  assign in_pos.z = pos_z_i;

  dcbf_store #(
    .Depth (MAX_PARTICLES),
    .IdxW  (IdxW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (in_acc && has_room),
    .wr_addr_i (count_q[IdxW-1:0]),
    .wr_data_i (in_pos),
    .rd_en_i   (issue),
    .rd_addr_i (j_q),
    .rd_data_o (cand)
  );

  dcbf_dist #(
    .IdxW (IdxW)
  ) u_dist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (out_free),
    .issue_i     (issue),
    .issue_idx_i (j_q),
    .pos_i       (pos_q),
    .cand_i      (cand),
    .cutoff_i    (cutoff_q),
    .res_o       (res),
    .res_idx_o   (res_idx)
  );

  // Frame control and result selection
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    j_d          = j_q;
    bonds_d      = bonds_q;
    ovf_d        = ovf_q;
    pend_valid_d = pend_valid_q;
    pend_idx_d   = pend_idx_q;
    out_valid_d  = out_valid_q && out_stall_i;
    kind_d       = kind_q;
    fidx_d       = fidx_q;
    sidx_d       = sidx_q;
    ocnt_d       = ocnt_q;
    oovf_d       = oovf_q;
    last_d       = last_q;

    // Count a hit; push the previous pending pair out, keep the new one back
    if (out_free && res.hit) begin
      if (bonds_q != BondSat) begin
        bonds_d = bonds_q + BondW'(1);
      end
      if (pend_valid_q) begin
        out_valid_d = 1'b1;
        kind_d      = KindBond;
        fidx_d      = OutIdxW'(pend_idx_q);
        sidx_d      = OutIdxW'(count_q);
        ocnt_d      = '0;
        oovf_d      = 1'b0;
        last_d      = 1'b0;
      end
      pend_valid_d = 1'b1;
      pend_idx_d   = res_idx;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (has_room) begin
            j_d = '0;
            state_d = (count_q == '0) ? ST_FLUSH : ST_SCAN;
          end else begin
            ovf_d = 1'b1;
            if (frame_end_i) begin
              state_d = ST_SUMM;
            end
          end
        end
      end
      ST_SCAN: begin
        if (out_free) begin
          j_d = j_q + IdxW'(1);
          if (CntW'(j_q) + CntW'(1) == count_q) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (!res.busy) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_q || out_free) begin
          if (pend_valid_q) begin
            out_valid_d  = 1'b1;
            kind_d       = KindBond;
            fidx_d       = OutIdxW'(pend_idx_q);
            sidx_d       = OutIdxW'(count_q);
            ocnt_d       = '0;
            oovf_d       = 1'b0;
            last_d       = !end_q;
            pend_valid_d = 1'b0;
          end
          count_d = count_q + CntW'(1);
          state_d = end_q ? ST_SUMM : ST_IDLE;
        end
      end
      ST_SUMM: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          kind_d      = KindSummary;
          fidx_d      = '0;
          sidx_d      = '0;
          ocnt_d      = bonds_q;
          oovf_d      = ovf_q;
          last_d      = 1'b1;
          count_d     = '0;
          bonds_d     = '0;
          ovf_d       = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      j_q          <= '0;
      bonds_q      <= '0;
      ovf_q        <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      cutoff_q     <= '0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      j_q          <= j_d;
      bonds_q      <= bonds_d;
      ovf_q        <= ovf_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      if (cfg_valid_i) begin
        cutoff_q <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    kind_q     <= kind_d;
    fidx_q     <= fidx_d;
    sidx_q     <= sidx_d;
    ocnt_q     <= ocnt_d;
    oovf_q     <= oovf_d;
    last_q     <= last_d;
    if (in_acc) begin
      pos_q <= in_pos;
      end_q <= frame_end_i;
    end
  end

  assign cfg_ready_o        = 1'b1;
  assign in_stall_o         = (state_q != ST_IDLE);
  assign out_valid_o        = out_valid_q;
  assign result_kind_o      = kind_q;
  assign first_index_o      = fidx_q;
  assign second_index_o     = sidx_q;
  assign frame_bond_count_o = ocnt_q;
  assign frame_overflow_o   = oovf_q;
  assign last_o             = last_q;

`ifndef SYNTH
  a_flush_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH) |-> !res.busy)
    else $error("flush entered with compares in flight");

  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_valid_q)
    else $error("pending pair left over after a particle");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_PARTICLES))
    else $error("particle count beyond capacity");

  a_bond_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q == KindBond) |-> (ocnt_q == '0 && !oovf_q))
    else $error("bond result carries summary fields");

  a_summary_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q == KindSummary) |-> last_q)
    else $error("summary not marked last");
`endif

endmodule
